// File: rtl/core/rmws_pkg.sv
// Shared constants, types and helper functions of the measurement window statistics block.
`default_nettype none

package rmws_pkg;

    localparam int HIST_DEPTH = 8;
    localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int KW         = $clog2(HIST_DEPTH + 1);

    localparam int LEV_W      = 6;
    localparam int QUAL_W     = 3;
    localparam int SEL_W      = 3;
    localparam int CNT_W      = 4;
    localparam int THR_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam int CMP_W      = (KW > CNT_W) ? KW : CNT_W;
    localparam int SUM_W      = $clog2(((1 << LEV_W) - 1) * HIST_DEPTH + 1);
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_AVG_SEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_CNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NM_SEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NM_NEED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NM_WIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NM_THR   = 3'd5;

    localparam logic [SEL_W-1:0] FLD_DL_LEV_FULL  = 3'd0;
    localparam logic [SEL_W-1:0] FLD_DL_LEV_SUB   = 3'd1;
    localparam logic [SEL_W-1:0] FLD_DL_QUAL_FULL = 3'd2;
    localparam logic [SEL_W-1:0] FLD_DL_QUAL_SUB  = 3'd3;
    localparam logic [SEL_W-1:0] FLD_UL_LEV_FULL  = 3'd4;
    localparam logic [SEL_W-1:0] FLD_UL_LEV_SUB   = 3'd5;
    localparam logic [SEL_W-1:0] FLD_UL_QUAL_FULL = 3'd6;
    localparam logic [SEL_W-1:0] FLD_UL_QUAL_SUB  = 3'd7;

    typedef struct packed {
        logic [LEV_W-1:0]  dl_level_full;
        logic [LEV_W-1:0]  dl_level_sub;
        logic [QUAL_W-1:0] dl_quality_full;
        logic [QUAL_W-1:0] dl_quality_sub;
        logic [LEV_W-1:0]  ul_level_full;
        logic [LEV_W-1:0]  ul_level_sub;
        logic [QUAL_W-1:0] ul_quality_full;
        logic [QUAL_W-1:0] ul_quality_sub;
    } t_report;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [KW-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DIVGO,
        S_DIV,
        S_DONE
    } t_state;

    function automatic logic [KW-1:0] clamp_cnt(input logic [CNT_W-1:0] c);
        logic [CMP_W-1:0] ce;
        ce = CMP_W'(c);
        if (ce > CMP_W'(HIST_DEPTH)) begin
            return KW'(HIST_DEPTH);
        end
        return KW'(c);
    endfunction

    function automatic logic [LEV_W-1:0] field_of(input t_report r,
                                                  input logic [SEL_W-1:0] sel);
        logic [LEV_W-1:0] v;
        case (sel)
            FLD_DL_LEV_FULL:  v = r.dl_level_full;
            FLD_DL_LEV_SUB:   v = r.dl_level_sub;
            FLD_DL_QUAL_FULL: v = LEV_W'(r.dl_quality_full);
            FLD_DL_QUAL_SUB:  v = LEV_W'(r.dl_quality_sub);
            FLD_UL_LEV_FULL:  v = r.ul_level_full;
            FLD_UL_LEV_SUB:   v = r.ul_level_sub;
            FLD_UL_QUAL_FULL: v = LEV_W'(r.ul_quality_full);
            FLD_UL_QUAL_SUB:  v = LEV_W'(r.ul_quality_sub);
            default:          v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(HIST_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(HIST_DEPTH - 1) : p - PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rmws_report_if.sv
// Input channel carrying one measurement report per beat.
`default_nettype none

interface rmws_report_if;
    logic                        valid;
    logic                        ready;
    logic [rmws_pkg::LEV_W-1:0]  dl_level_full;
    logic [rmws_pkg::LEV_W-1:0]  dl_level_sub;
    logic [rmws_pkg::QUAL_W-1:0] dl_quality_full;
    logic [rmws_pkg::QUAL_W-1:0] dl_quality_sub;
    logic [rmws_pkg::LEV_W-1:0]  ul_level_full;
    logic [rmws_pkg::LEV_W-1:0]  ul_level_sub;
    logic [rmws_pkg::QUAL_W-1:0] ul_quality_full;
    logic [rmws_pkg::QUAL_W-1:0] ul_quality_sub;

    modport source (
        output valid, dl_level_full, dl_level_sub, dl_quality_full, dl_quality_sub,
               ul_level_full, ul_level_sub, ul_quality_full, ul_quality_sub,
        input  ready
    );
    modport sink (
        input  valid, dl_level_full, dl_level_sub, dl_quality_full, dl_quality_sub,
               ul_level_full, ul_level_sub, ul_quality_full, ul_quality_sub,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/rmws_result_if.sv
// Output channel carrying one window result per beat.
`default_nettype none

interface rmws_result_if;
    logic                       valid;
    logic                       ready;
    logic [rmws_pkg::LEV_W-1:0] window_average;
    logic                       n_of_m_met;

    modport source (output valid, window_average, n_of_m_met, input ready);
    modport sink   (input valid, window_average, n_of_m_met, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rmws_ring.sv
// Report history ring: one write port, one registered read port, per-slot valid bits.
`default_nettype none

module rmws_ring (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_we,
    input  wire logic [rmws_pkg::PTR_W-1:0] i_waddr,
    input  rmws_pkg::t_report               i_wdata,
    input  wire logic [rmws_pkg::PTR_W-1:0] i_raddr,
    output rmws_pkg::t_report               o_rdata
);

    rmws_pkg::t_report                    r_mem [rmws_pkg::HIST_DEPTH];
    logic [rmws_pkg::HIST_DEPTH-1:0]      r_valid;
    rmws_pkg::t_report                    r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // pass a beat written to the slot being read straight through;
    // an unwritten slot reads as a cleared report
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else if (r_valid[i_raddr]) begin
            r_rdata <= r_mem[i_raddr];
        end else begin
            r_rdata <= '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/rmws_div.sv
// Restoring divider, one quotient bit per cycle through a shared subtractor.
`default_nettype none

module rmws_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  rmws_pkg::t_div_req i_req,
    output rmws_pkg::t_div_rsp o_rsp
);

    logic [rmws_pkg::KW-1:0]        r_rem, n_rem;
    logic [rmws_pkg::SUM_W-1:0]     r_quo, n_quo;
    logic [rmws_pkg::KW-1:0]        r_dvs, n_dvs;
    logic [rmws_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [rmws_pkg::KW:0]          trial;
    logic [rmws_pkg::KW:0]          diff;

    always_comb begin
        trial  = {r_rem, r_quo[rmws_pkg::SUM_W-1]};
        diff   = trial - {1'b0, r_dvs};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract where it fits
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[rmws_pkg::KW-1:0];
                n_quo = {r_quo[rmws_pkg::SUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[rmws_pkg::KW-1:0];
                n_quo = {r_quo[rmws_pkg::SUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + rmws_pkg::DIV_CNT_W'(1);
            if (r_cnt == rmws_pkg::DIV_CNT_W'(rmws_pkg::SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp = {r_done, r_quo};

endmodule

`default_nettype wire

// File: rtl/core/radio_measurement_window_stats.sv
// Radio measurement window statistics: report ring, window average and N of M check.
//
// Channels: i_report takes one measurement report per beat (valid/ready);
// o_result gives one beat per report with the truncated average of the selected
// field over the latest avg_count reports and the N of M flag over the latest
// nm_window reports. Registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data, by the user only while the block is idle; the block does not check it.
// Sequence: an accepted report is stored on the accept edge, then a sequencer
// walks the ring one slot a cycle, newest first, over max(avg_count, nm_window)
// slots (0 to 8, counts saturating at the ring depth), then the restoring
// divider is loaded and produces the quotient, and the result register then
// loads it and raises o_result.valid. One report is in work at a time;
// i_report.ready is high only while the sequencer is idle, so a new report is
// not taken before the last one has reached the result register.
// Reset (synchronous, active low) clears the ring valid bits so every slot
// reads as zero, rewinds the write pointer and restores the register defaults.
// When the receiver stalls, the result register holds its beat; the
// sequencer may take and process the next report, then waits for the
// result register to drain before loading it.
`default_nettype none

module radio_measurement_window_stats (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rmws_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rmws_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rmws_report_if.sink                          i_report,
    rmws_result_if.source                        o_result
);

    // configuration registers
    logic [rmws_pkg::SEL_W-1:0] r_avg_sel;
    logic [rmws_pkg::CNT_W-1:0] r_avg_cnt;
    logic [rmws_pkg::SEL_W-1:0] r_nm_sel;
    logic [rmws_pkg::CNT_W-1:0] r_nm_need;
    logic [rmws_pkg::CNT_W-1:0] r_nm_win;
    logic [rmws_pkg::THR_W-1:0] r_nm_thr;

    rmws_pkg::t_state             r_state, n_state;
    logic [rmws_pkg::PTR_W-1:0]   r_wp, n_wp;
    logic [rmws_pkg::PTR_W-1:0]   r_slot, n_slot;
    logic [rmws_pkg::KW-1:0]      r_j, n_j;
    logic [rmws_pkg::KW-1:0]      r_ka, n_ka;
    logic [rmws_pkg::KW-1:0]      r_km, n_km;
    logic [rmws_pkg::KW-1:0]      r_len, n_len;
    logic [rmws_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [rmws_pkg::KW-1:0]      r_hits, n_hits;
    logic                         r_out_valid, n_out_valid;
    logic [rmws_pkg::LEV_W-1:0]   r_out_avg, n_out_avg;
    logic                         r_out_met, n_out_met;

    logic                         accept;
    logic                         in_ready;
    logic                         load_out;
    logic                         div_start;
    logic                         walk_last;
    logic [rmws_pkg::KW-1:0]      ka_cfg;
    logic [rmws_pkg::KW-1:0]      km_cfg;
    logic [rmws_pkg::LEV_W-1:0]   fa;
    logic [rmws_pkg::LEV_W-1:0]   fn;
    rmws_pkg::t_report            wdata;
    rmws_pkg::t_report            rdata;
    rmws_pkg::t_div_req           div_req;
    rmws_pkg::t_div_rsp           div_rsp;

    assign wdata = {i_report.dl_level_full, i_report.dl_level_sub,
                    i_report.dl_quality_full, i_report.dl_quality_sub,
                    i_report.ul_level_full, i_report.ul_level_sub,
                    i_report.ul_quality_full, i_report.ul_quality_sub};

    assign accept    = i_report.valid && in_ready;
    assign ka_cfg    = rmws_pkg::clamp_cnt(r_avg_cnt);
    assign km_cfg    = rmws_pkg::clamp_cnt(r_nm_win);
    assign walk_last = (r_j + rmws_pkg::KW'(1)) == r_len;
    assign fa        = rmws_pkg::field_of(rdata, r_avg_sel);
    assign fn        = rmws_pkg::field_of(rdata, r_nm_sel);

    // address the next slot so the registered read lines up with r_slot
    rmws_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (wdata),
        .i_raddr (n_slot),
        .o_rdata (rdata)
    );

    assign div_req = {div_start, r_sum, r_ka};

    rmws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_sel <= '0;
            r_avg_cnt <= rmws_pkg::CNT_W'(1);
            r_nm_sel  <= '0;
            r_nm_need <= rmws_pkg::CNT_W'(1);
            r_nm_win  <= rmws_pkg::CNT_W'(1);
            r_nm_thr  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rmws_pkg::CFG_AVG_SEL: r_avg_sel <= i_cfg_data[rmws_pkg::SEL_W-1:0];
                rmws_pkg::CFG_AVG_CNT: r_avg_cnt <= i_cfg_data[rmws_pkg::CNT_W-1:0];
                rmws_pkg::CFG_NM_SEL:  r_nm_sel  <= i_cfg_data[rmws_pkg::SEL_W-1:0];
                rmws_pkg::CFG_NM_NEED: r_nm_need <= i_cfg_data[rmws_pkg::CNT_W-1:0];
                rmws_pkg::CFG_NM_WIN:  r_nm_win  <= i_cfg_data[rmws_pkg::CNT_W-1:0];
                rmws_pkg::CFG_NM_THR:  r_nm_thr  <= i_cfg_data[rmws_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmws_pkg::S_IDLE: begin
                if (i_report.valid) begin
                    n_state = ((ka_cfg > km_cfg ? ka_cfg : km_cfg) == '0) ?
                              rmws_pkg::S_DIVGO : rmws_pkg::S_WALK;
                end
            end
            rmws_pkg::S_WALK: begin
                if (walk_last) begin
                    n_state = rmws_pkg::S_DIVGO;
                end
            end
            rmws_pkg::S_DIVGO: n_state = rmws_pkg::S_DIV;
            rmws_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    n_state = rmws_pkg::S_DONE;
                end
            end
            rmws_pkg::S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = rmws_pkg::S_IDLE;
                end
            end
            default: n_state = rmws_pkg::S_IDLE;
        endcase
    end

    // state decoded controls
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            rmws_pkg::S_IDLE:  in_ready  = 1'b1;
            rmws_pkg::S_DIVGO: div_start = 1'b1;
            rmws_pkg::S_DONE:  load_out  = !r_out_valid || o_result.ready;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_wp        = r_wp;
        n_slot      = r_slot;
        n_j         = r_j;
        n_ka        = r_ka;
        n_km        = r_km;
        n_len       = r_len;
        n_sum       = r_sum;
        n_hits      = r_hits;
        n_out_avg   = r_out_avg;
        n_out_met   = r_out_met;
        n_out_valid = r_out_valid;

        if (accept) begin
            // newest report is at the slot being written; walk backwards from it
            n_wp   = rmws_pkg::slot_inc(r_wp);
            n_slot = r_wp;
            n_j    = '0;
            n_ka   = ka_cfg;
            n_km   = km_cfg;
            n_len  = (ka_cfg > km_cfg) ? ka_cfg : km_cfg;
            n_sum  = '0;
            n_hits = '0;
        end

        if (r_state == rmws_pkg::S_WALK) begin
            if (r_j < r_ka) begin
                n_sum = r_sum + rmws_pkg::SUM_W'(fa);
            end
            if ((r_j < r_km) && ({1'b0, fn} >= r_nm_thr)) begin
                n_hits = r_hits + rmws_pkg::KW'(1);
            end
            n_j    = r_j + rmws_pkg::KW'(1);
            n_slot = rmws_pkg::slot_dec(r_slot);
        end

        if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_avg   = (r_ka == '0) ? '0 : div_rsp.quotient[rmws_pkg::LEV_W-1:0];
            n_out_met   = (r_km != '0) &&
                          (rmws_pkg::CMP_W'(r_hits) >= rmws_pkg::CMP_W'(r_nm_need));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmws_pkg::S_IDLE;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_j       <= n_j;
        r_ka      <= n_ka;
        r_km      <= n_km;
        r_len     <= n_len;
        r_sum     <= n_sum;
        r_hits    <= n_hits;
        r_out_avg <= n_out_avg;
        r_out_met <= n_out_met;
    end

    assign i_report.ready          = in_ready;
    assign o_result.valid          = r_out_valid;
    assign o_result.window_average = r_out_avg;
    assign o_result.n_of_m_met     = r_out_met;

endmodule

`default_nettype wire

// File: rtl/core/rmws_checker.sv
// Port level checks on the measurement window statistics block, bound to the top level.
`default_nettype none

module rmws_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [rmws_pkg::LEV_W-1:0] i_out_avg,
    input wire logic                       i_out_met
);

    // one report in work at a time: ready drops after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("report accepted while previous one in work");

    // reset leaves the block idle with no pending result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_avg) && $stable(i_out_met))
        else $error("result payload changed while stalled");

endmodule

bind radio_measurement_window_stats rmws_checker u_rmws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_report.valid),
    .i_in_ready  (i_report.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_avg   (o_result.window_average),
    .i_out_met   (o_result.n_of_m_met)
);

`default_nettype wire

// File: test/radio_measurement_window_stats_tb.sv
// Testbench for the measurement window statistics block: predicted results checked per beat.

typedef struct packed {
    logic [rmws_pkg::LEV_W-1:0] window_average;
    logic                       n_of_m_met;
} t_window_result;

class window_stats_board;
    logic [rmws_pkg::SEL_W-1:0] avg_sel;
    logic [rmws_pkg::CNT_W-1:0] avg_cnt;
    logic [rmws_pkg::SEL_W-1:0] nm_sel;
    logic [rmws_pkg::CNT_W-1:0] nm_need;
    logic [rmws_pkg::CNT_W-1:0] nm_win;
    logic [rmws_pkg::THR_W-1:0] nm_thr;
    int unsigned                ring[rmws_pkg::HIST_DEPTH][8];
    int unsigned                next_slot;
    t_window_result             due_results[$];
    int                         errors;

    function new();
        avg_sel   = rmws_pkg::FLD_DL_LEV_FULL;
        avg_cnt   = 1;
        nm_sel    = rmws_pkg::FLD_DL_LEV_FULL;
        nm_need   = 1;
        nm_win    = 1;
        nm_thr    = 0;
        next_slot = 0;
        errors    = 0;
        foreach (ring[s, f]) ring[s][f] = 0;
    endfunction

    function void note_config(logic [rmws_pkg::CFG_IDX_W-1:0] idx,
                              logic [rmws_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rmws_pkg::CFG_AVG_SEL: avg_sel = data[rmws_pkg::SEL_W-1:0];
            rmws_pkg::CFG_AVG_CNT: avg_cnt = data[rmws_pkg::CNT_W-1:0];
            rmws_pkg::CFG_NM_SEL:  nm_sel  = data[rmws_pkg::SEL_W-1:0];
            rmws_pkg::CFG_NM_NEED: nm_need = data[rmws_pkg::CNT_W-1:0];
            rmws_pkg::CFG_NM_WIN:  nm_win  = data[rmws_pkg::CNT_W-1:0];
            rmws_pkg::CFG_NM_THR:  nm_thr  = data[rmws_pkg::THR_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned clamp(int unsigned k);
        return (k > rmws_pkg::HIST_DEPTH) ? rmws_pkg::HIST_DEPTH : k;
    endfunction

    // i-th of the latest k reports, oldest first
    function int unsigned latest(int unsigned k, int unsigned i,
                                 logic [rmws_pkg::SEL_W-1:0] sel);
        return ring[(next_slot + rmws_pkg::HIST_DEPTH - k + i) % rmws_pkg::HIST_DEPTH][sel];
    endfunction

    function void note_report(rmws_pkg::t_report r);
        int unsigned    k;
        int unsigned    sum;
        int unsigned    hits;
        t_window_result w;
        ring[next_slot][rmws_pkg::FLD_DL_LEV_FULL]  = r.dl_level_full;
        ring[next_slot][rmws_pkg::FLD_DL_LEV_SUB]   = r.dl_level_sub;
        ring[next_slot][rmws_pkg::FLD_DL_QUAL_FULL] = r.dl_quality_full;
        ring[next_slot][rmws_pkg::FLD_DL_QUAL_SUB]  = r.dl_quality_sub;
        ring[next_slot][rmws_pkg::FLD_UL_LEV_FULL]  = r.ul_level_full;
        ring[next_slot][rmws_pkg::FLD_UL_LEV_SUB]   = r.ul_level_sub;
        ring[next_slot][rmws_pkg::FLD_UL_QUAL_FULL] = r.ul_quality_full;
        ring[next_slot][rmws_pkg::FLD_UL_QUAL_SUB]  = r.ul_quality_sub;
        next_slot = (next_slot + 1) % rmws_pkg::HIST_DEPTH;

        k   = clamp(avg_cnt);
        sum = 0;
        for (int unsigned i = 0; i < k; i++) sum += latest(k, i, avg_sel);
        w.window_average = (k == 0) ? '0 : rmws_pkg::LEV_W'(sum / k);

        // stop at the first report that makes the count; the hardware counts on, same flag
        k            = clamp(nm_win);
        hits         = 0;
        w.n_of_m_met = 1'b0;
        for (int unsigned i = 0; i < k; i++) begin
            if (latest(k, i, nm_sel) >= nm_thr) hits++;
            if (hits >= nm_need) begin
                w.n_of_m_met = 1'b1;
                break;
            end
        end
        due_results.push_back(w);
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    task check_result(logic [rmws_pkg::LEV_W-1:0] avg, logic met);
        t_window_result w;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("result avg=%0d met=%0d with nothing due", avg, met));
            return;
        end
        w = due_results.pop_front();
        if (avg !== w.window_average)
            report_mismatch($sformatf("window_average %0d, predicted %0d",
                                      avg, w.window_average));
        if (met !== w.n_of_m_met)
            report_mismatch($sformatf("n_of_m_met %0b, predicted %0b", met, w.n_of_m_met));
    endtask
endclass

module radio_measurement_window_stats_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes past the register list, writes there must change nothing
    localparam logic [rmws_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [rmws_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int RANDOM_REPORTS  = 600;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 25;

    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rmws_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rmws_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rmws_report_if report_ch ();
    rmws_result_if result_ch ();

    window_stats_board board = new();
    bit                hold_off_req;
    int unsigned       reports_sent;

    always #5 i_clk = ~i_clk;

    radio_measurement_window_stats dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_report   (report_ch),
        .o_result   (result_ch)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            board.check_result(result_ch.window_average, result_ch.n_of_m_met);
    end

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial begin : receiver
        t_rx_mode    mode;
        int unsigned mode_left;
        result_ch.ready <= 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            case (mode)
                RX_OPEN:   result_ch.ready <= 1'b1;
                RX_HALF:   result_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: result_ch.ready <= ($urandom_range(0, 7) == 0);
                default:   result_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic drive_report(rmws_pkg::t_report r);
        report_ch.dl_level_full   <= r.dl_level_full;
        report_ch.dl_level_sub    <= r.dl_level_sub;
        report_ch.dl_quality_full <= r.dl_quality_full;
        report_ch.dl_quality_sub  <= r.dl_quality_sub;
        report_ch.ul_level_full   <= r.ul_level_full;
        report_ch.ul_level_sub    <= r.ul_level_sub;
        report_ch.ul_quality_full <= r.ul_quality_full;
        report_ch.ul_quality_sub  <= r.ul_quality_sub;
    endtask

    // offer one report and hold it until the beat is taken
    task automatic send_report(rmws_pkg::t_report r);
        report_ch.valid <= 1'b1;
        drive_report(r);
        do @(posedge i_clk); while (!report_ch.ready);
        board.note_report(r);
        reports_sent++;
    endtask

    task automatic write_reg(logic [rmws_pkg::CFG_IDX_W-1:0] idx,
                             logic [rmws_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.note_config(idx, data);
    endtask

    // drop valid and wait until every predicted beat has come out
    task automatic settle();
        report_ch.valid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_value(int unsigned top);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    function automatic logic [rmws_pkg::CNT_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return rmws_pkg::CNT_W'(rmws_pkg::HIST_DEPTH);
            3:       return '1;
            default: return rmws_pkg::CNT_W'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic rmws_pkg::t_report random_report();
        rmws_pkg::t_report r;
        r.dl_level_full   = rmws_pkg::LEV_W'(pick_value(63));
        r.dl_level_sub    = rmws_pkg::LEV_W'(pick_value(63));
        r.dl_quality_full = rmws_pkg::QUAL_W'(pick_value(7));
        r.dl_quality_sub  = rmws_pkg::QUAL_W'(pick_value(7));
        r.ul_level_full   = rmws_pkg::LEV_W'(pick_value(63));
        r.ul_level_sub    = rmws_pkg::LEV_W'(pick_value(63));
        r.ul_quality_full = rmws_pkg::QUAL_W'(pick_value(7));
        r.ul_quality_sub  = rmws_pkg::QUAL_W'(pick_value(7));
        return r;
    endfunction

    function automatic rmws_pkg::t_report flat_report(logic [rmws_pkg::LEV_W-1:0] lev,
                                                      logic [rmws_pkg::QUAL_W-1:0] qual);
        rmws_pkg::t_report r;
        r.dl_level_full   = lev;
        r.dl_level_sub    = lev;
        r.dl_quality_full = qual;
        r.dl_quality_sub  = qual;
        r.ul_level_full   = lev;
        r.ul_level_sub    = lev;
        r.ul_quality_full = qual;
        r.ul_quality_sub  = qual;
        return r;
    endfunction

    task automatic random_settings();
        logic [rmws_pkg::SEL_W-1:0] nsel;
        logic [rmws_pkg::CNT_W-1:0] win;
        int unsigned                need_top;
        int unsigned                thr_top;
        // upper data bits are random: only the low bits of each register count
        write_reg(rmws_pkg::CFG_AVG_SEL, rmws_pkg::CFG_DATA_W'($urandom_range(0, 127)));
        write_reg(rmws_pkg::CFG_AVG_CNT, {3'($urandom), pick_count()});
        nsel = rmws_pkg::SEL_W'($urandom_range(0, 7));
        write_reg(rmws_pkg::CFG_NM_SEL, {4'($urandom), nsel});
        win = pick_count();
        write_reg(rmws_pkg::CFG_NM_WIN, {3'($urandom), win});
        need_top = ((win > rmws_pkg::HIST_DEPTH) ? rmws_pkg::HIST_DEPTH : win) + 1;
        if ($urandom_range(0, 7) == 0)
            write_reg(rmws_pkg::CFG_NM_NEED, rmws_pkg::CFG_DATA_W'($urandom_range(0, 127)));
        else
            write_reg(rmws_pkg::CFG_NM_NEED,
                      rmws_pkg::CFG_DATA_W'($urandom_range(0, need_top)));
        // keep the threshold mostly within reach of the tested field
        thr_top = nsel[1] ? 8 : 64;
        if ($urandom_range(0, 7) == 0)
            write_reg(rmws_pkg::CFG_NM_THR, rmws_pkg::CFG_DATA_W'($urandom_range(0, 127)));
        else
            write_reg(rmws_pkg::CFG_NM_THR,
                      rmws_pkg::CFG_DATA_W'($urandom_range(0, thr_top)));
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      rmws_pkg::CFG_DATA_W'($urandom_range(0, 127)));
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_part();
        logic [rmws_pkg::CNT_W-1:0] avg_cnts[8] =
            '{4'd0, 4'd15, 4'd8, 4'd3, 4'd7, 4'd2, 4'd5, 4'd1};
        logic [rmws_pkg::CNT_W-1:0] wins[8] =
            '{4'd0, 4'd12, 4'd3, 4'd8, 4'd8, 4'd5, 4'd2, 4'd1};
        logic [rmws_pkg::CNT_W-1:0] needs[8] =
            '{4'd0, 4'd0, 4'd5, 4'd1, 4'd4, 4'd5, 4'd2, 4'd1};
        logic [rmws_pkg::THR_W-1:0] thrs[8] =
            '{7'd0, 7'd127, 7'd0, 7'd127, 7'd64, 7'd63, 7'd7, 7'd8};
        logic [rmws_pkg::SEL_W-1:0] sel;
        // register defaults straight after reset
        send_report(flat_report('1, '1));
        send_report(flat_report('0, '0));
        settle();
        // full window over a ring with empty slots, which read as zero
        write_reg(rmws_pkg::CFG_AVG_CNT, rmws_pkg::CFG_DATA_W'(rmws_pkg::HIST_DEPTH));
        write_reg(rmws_pkg::CFG_NM_SEL, rmws_pkg::CFG_DATA_W'(rmws_pkg::FLD_UL_QUAL_SUB));
        write_reg(rmws_pkg::CFG_NM_WIN, rmws_pkg::CFG_DATA_W'(rmws_pkg::HIST_DEPTH));
        write_reg(rmws_pkg::CFG_NM_NEED, rmws_pkg::CFG_DATA_W'(2));
        write_reg(rmws_pkg::CFG_NM_THR, rmws_pkg::CFG_DATA_W'(1));
        i_cfg_we <= 1'b0;
        send_report(flat_report('1, '1));
        settle();
        // each field select on both sides, with the count and threshold corner cases
        for (int s = 0; s < 8; s++) begin
            sel = rmws_pkg::SEL_W'(s);
            write_reg(rmws_pkg::CFG_AVG_SEL, rmws_pkg::CFG_DATA_W'(sel));
            write_reg(rmws_pkg::CFG_AVG_CNT, rmws_pkg::CFG_DATA_W'(avg_cnts[s]));
            write_reg(rmws_pkg::CFG_NM_SEL, rmws_pkg::CFG_DATA_W'(~sel));
            write_reg(rmws_pkg::CFG_NM_WIN, rmws_pkg::CFG_DATA_W'(wins[s]));
            write_reg(rmws_pkg::CFG_NM_NEED, rmws_pkg::CFG_DATA_W'(needs[s]));
            write_reg(rmws_pkg::CFG_NM_THR, thrs[s]);
            if (s == 2) write_reg(CFG_SPARE_HI, '1);
            i_cfg_we <= 1'b0;
            if (s % 2 == 0) begin
                send_report(flat_report('1, '1));
                send_report(flat_report(6'h2a, 3'h5));
            end else begin
                send_report(flat_report('0, '0));
                send_report(flat_report(6'h15, 3'h2));
            end
            settle();
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned phase_left;
        int unsigned burst_left;
        bit          no_gaps;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        report_ch.valid <= 1'b0;
        drive_report('0);
        hold_off_req = 1'b0;
        reports_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();

        reports_sent = 0;
        phase        = 0;
        while (reports_sent < RANDOM_REPORTS) begin
            random_settings();
            phase_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(4, 30);
            no_gaps    = ($urandom_range(0, 3) == 0);
            // keep offering while the receiver holds off, so the block backs up
            if (phase == 2) begin
                hold_off_req = 1'b1;
                no_gaps      = 1'b1;
                phase_left   = 40;
            end
            burst_left = $urandom_range(1, 12);
            repeat (phase_left) begin
                send_report(random_report());
                if (!no_gaps) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        report_ch.valid <= 1'b0;
                        repeat ($urandom_range(1, 24)) @(posedge i_clk);
                        burst_left = $urandom_range(1, 12);
                    end
                end
            end
            settle();
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
